// ----- rtl/pmld_pkg.sv -----
// -----------------------------------------------------------------------------
// pmld_pkg: shared types and constants of the PSK max-log LLR demapper
// Field widths, operation and register codes, defaults of the top-level
// parameters and the control word that travels with each LLR beat.
// -----------------------------------------------------------------------------
package pmld_pkg;

  // Defaults of the top-level parameters.
  localparam int unsigned DEF_MAX_POINTS   = 16;
  localparam int unsigned DEF_MAX_BITS     = 4;
  localparam int unsigned DEF_MAX_SUBSET   = 8;
  localparam int unsigned DEF_SAMPLE_WIDTH = 16;

  // Fixed field widths.
  localparam int unsigned OPCODE_W     = 2;
  localparam int unsigned POINT_SLOT_W = 4;
  localparam int unsigned BIT_SEL_W    = 2;
  localparam int unsigned LIST_SLOT_W  = 3;
  localparam int unsigned POINT_REF_W  = 4;
  localparam int unsigned BIT_NUM_W    = 2;

  // Configuration registers.
  localparam int unsigned BPS_W       = 3;
  localparam int unsigned SUBSET_W    = 4;
  localparam int unsigned CFG_DATA_W  = 4;
  localparam int unsigned CFG_INDEX_W = 1;

  localparam logic [BPS_W-1:0]    BPS_RESET    = 3'd2;
  localparam logic [SUBSET_W-1:0] SUBSET_RESET = 4'd2;

  // Lanes of the max tree; covers the largest set list.
  localparam int unsigned TREE_LANES = 8;
  localparam int unsigned TREE_HALF  = TREE_LANES / 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD_POINT = 2'd0,
    OP_LOAD_ZERO  = 2'd1,
    OP_LOAD_ONE   = 2'd2,
    OP_DEMAP      = 2'd3
  } opcode_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BITS_PER_SYMBOL = 1'b0,
    CFG_SUBSET_SIZE     = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic [BIT_NUM_W-1:0] bit_number;
    logic                 last_bit;
  } beat_ctl_t;

endpackage

// ----- rtl/pmld_if.sv -----
// -----------------------------------------------------------------------------
// pmld_if: channel interfaces of the PSK max-log LLR demapper
// Input channel carries load and demap items, output channel carries LLRs.
// -----------------------------------------------------------------------------
interface pmld_in_if #(
  parameter int unsigned SAMPLE_WIDTH = pmld_pkg::DEF_SAMPLE_WIDTH
);
  import pmld_pkg::*;

  logic                           valid;
  logic                           ready;
  logic [OPCODE_W-1:0]            opcode;
  logic [POINT_SLOT_W-1:0]        point_slot;
  logic [BIT_SEL_W-1:0]           bit_select;
  logic [LIST_SLOT_W-1:0]         list_slot;
  logic [POINT_REF_W-1:0]         point_ref;
  logic signed [SAMPLE_WIDTH-1:0] sample_re;
  logic signed [SAMPLE_WIDTH-1:0] sample_im;

  modport source (
    output valid, opcode, point_slot, bit_select, list_slot, point_ref, sample_re, sample_im,
    input  ready
  );
  modport sink (
    input  valid, opcode, point_slot, bit_select, list_slot, point_ref, sample_re, sample_im,
    output ready
  );
endinterface

interface pmld_out_if #(
  parameter int unsigned LLR_WIDTH = 2 * pmld_pkg::DEF_SAMPLE_WIDTH + 3
);
  import pmld_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [LLR_WIDTH-1:0] llr;
  logic [BIT_NUM_W-1:0]        bit_number;
  logic                        last_bit;

  modport source (output valid, llr, bit_number, last_bit, input ready);
  modport sink   (input valid, llr, bit_number, last_bit, output ready);
endinterface

// ----- rtl/psk_maxlog_llr_demapper.sv -----
// -----------------------------------------------------------------------------
// psk_maxlog_llr_demapper: max-log soft demapper for PSK constellations
// Load items fill the point table and, for each bit, its zero-set and one-set
// point lists; a demap item takes one Q2.14 sample and returns one LLR per
// bit, 2*(max0 - max1), bit 0 first, with last_bit set on the final one.
// Load items go no further than S1. A demap item holds the serializer for
// bits_per_symbol beats (one to four); one LLR leaves per cycle while the
// output is not stalled, and the serializer takes the next sample in the
// cycle its last beat leaves. Each sample passes S1, S2, the serializer
// and the registers of the LLR pipe before its LLRs appear. Tables must
// be loaded before they are used; configuration must be written only while
// the block is idle, and the block itself does not enforce this.
// -----------------------------------------------------------------------------
module psk_maxlog_llr_demapper #(
  parameter int unsigned MAX_POINTS   = pmld_pkg::DEF_MAX_POINTS,
  parameter int unsigned MAX_BITS     = pmld_pkg::DEF_MAX_BITS,
  parameter int unsigned MAX_SUBSET   = pmld_pkg::DEF_MAX_SUBSET,
  parameter int unsigned SAMPLE_WIDTH = pmld_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pmld_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [pmld_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  pmld_in_if.sink                            sample_in,
  pmld_out_if.source                         llr_out
);
  import pmld_pkg::*;

  localparam int unsigned PROD_W    = 2 * SAMPLE_WIDTH;
  localparam int unsigned PROJ_W    = PROD_W + 1;
  localparam int unsigned LLR_W     = PROJ_W + 2;
  localparam int unsigned PT_IDX_W  = $clog2(MAX_POINTS);
  localparam int unsigned BIT_IDX_W = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  localparam int unsigned SUB_IDX_W = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers and their clamped working values.
  // ---------------------------------------------------------------------------
  logic [BPS_W-1:0]    bps_q, nb_c;
  logic [SUBSET_W-1:0] subset_q, ns_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bps_q    <= BPS_RESET;
      subset_q <= SUBSET_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_BITS_PER_SYMBOL: bps_q    <= cfg_wdata_i[BPS_W-1:0];
        CFG_SUBSET_SIZE:     subset_q <= cfg_wdata_i[SUBSET_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero count acts as one; counts above the table size act as the maximum.
  always_comb begin
    if (bps_q == '0) begin
      nb_c = BPS_W'(1);
    end else if (bps_q > BPS_W'(MAX_BITS)) begin
      nb_c = BPS_W'(MAX_BITS);
    end else begin
      nb_c = bps_q;
    end
    if (subset_q == '0) begin
      ns_c = SUBSET_W'(1);
    end else if (subset_q > SUBSET_W'(MAX_SUBSET)) begin
      ns_c = SUBSET_W'(MAX_SUBSET);
    end else begin
      ns_c = subset_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage S1: the accepted item. Loads update the tables when they leave S1,
  // which is also where a demap reads the point table. Loads leave only when
  // S2 is free or moving, so a demap ahead of them has already captured the
  // set lists on its way from S2 into the serializer.
  // ---------------------------------------------------------------------------
  logic                           s1_v_q;
  opcode_e                        s1_op_q;
  logic [POINT_SLOT_W-1:0]        s1_pslot_q;
  logic [BIT_SEL_W-1:0]           s1_bsel_q;
  logic [LIST_SLOT_W-1:0]         s1_lslot_q;
  logic [POINT_REF_W-1:0]         s1_pref_q;
  logic signed [SAMPLE_WIDTH-1:0] s1_re_q, s1_im_q;
  logic                           s1_adv, s2_rdy, in_xfer;
  logic                           pt_ok, list_ok;

  assign sample_in.ready = !s1_v_q || s2_rdy;
  assign in_xfer         = sample_in.valid && sample_in.ready;
  assign s1_adv          = s1_v_q && s2_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (sample_in.ready) begin
      s1_v_q <= sample_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q    <= opcode_e'(sample_in.opcode);
      s1_pslot_q <= sample_in.point_slot;
      s1_bsel_q  <= sample_in.bit_select;
      s1_lslot_q <= sample_in.list_slot;
      s1_pref_q  <= sample_in.point_ref;
      s1_re_q    <= sample_in.sample_re;
      s1_im_q    <= sample_in.sample_im;
    end
  end

  // Tables hold no reset value; they are loaded before use.
  logic signed [SAMPLE_WIDTH-1:0] pt_re_q [MAX_POINTS];
  logic signed [SAMPLE_WIDTH-1:0] pt_im_q [MAX_POINTS];
  logic [POINT_REF_W-1:0]         zero_list_q [MAX_BITS][MAX_SUBSET];
  logic [POINT_REF_W-1:0]         one_list_q  [MAX_BITS][MAX_SUBSET];

  // Loads that name a slot beyond the tables are dropped.
  assign pt_ok   = (POINT_SLOT_W+1)'(s1_pslot_q) < (POINT_SLOT_W+1)'(MAX_POINTS);
  assign list_ok = ((BIT_SEL_W+1)'(s1_bsel_q) < (BIT_SEL_W+1)'(MAX_BITS)) &&
                   ((LIST_SLOT_W+1)'(s1_lslot_q) < (LIST_SLOT_W+1)'(MAX_SUBSET));

  always_ff @(posedge clk_i) begin
    if (s1_adv && (s1_op_q == OP_LOAD_POINT) && pt_ok) begin
      pt_re_q[s1_pslot_q[PT_IDX_W-1:0]] <= s1_re_q;
      pt_im_q[s1_pslot_q[PT_IDX_W-1:0]] <= s1_im_q;
    end
    if (s1_adv && (s1_op_q == OP_LOAD_ZERO) && list_ok) begin
      zero_list_q[s1_bsel_q[BIT_IDX_W-1:0]][s1_lslot_q[SUB_IDX_W-1:0]] <= s1_pref_q;
    end
    if (s1_adv && (s1_op_q == OP_LOAD_ONE) && list_ok) begin
      one_list_q[s1_bsel_q[BIT_IDX_W-1:0]][s1_lslot_q[SUB_IDX_W-1:0]] <= s1_pref_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage S2: one pair of products per constellation point, all in parallel.
  // Only demap items enter S2.
  // ---------------------------------------------------------------------------
  logic                     s2_v_q;
  logic signed [PROD_W-1:0] prod_re [MAX_POINTS];
  logic signed [PROD_W-1:0] prod_im [MAX_POINTS];
  logic signed [PROD_W-1:0] s2_pre_q [MAX_POINTS];
  logic signed [PROD_W-1:0] s2_pim_q [MAX_POINTS];
  logic                     x_take;

  always_comb begin
    for (int k = 0; k < MAX_POINTS; k++) begin
      prod_re[k] = s1_re_q * pt_re_q[k];
      prod_im[k] = s1_im_q * pt_im_q[k];
    end
  end

  assign s2_rdy = !s2_v_q || x_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_q <= s1_v_q && (s1_op_q == OP_DEMAP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && (s1_op_q == OP_DEMAP)) begin
      s2_pre_q <= prod_re;
      s2_pim_q <= prod_im;
    end
  end

  // ---------------------------------------------------------------------------
  // Serializer X: holds the projections and a copy of the set lists of one
  // sample and issues one beat per bit. It takes the next sample in the cycle
  // its last beat leaves, so samples follow each other without a gap.
  // ---------------------------------------------------------------------------
  logic                     x_v_q;
  logic [BIT_IDX_W-1:0]     x_bit_q;
  logic signed [PROJ_W-1:0] x_proj_q [MAX_POINTS];
  logic [POINT_REF_W-1:0]   x_zero_q [MAX_BITS][MAX_SUBSET];
  logic [POINT_REF_W-1:0]   x_one_q  [MAX_BITS][MAX_SUBSET];
  logic                     x_last, x_emit, beat_ready;
  beat_ctl_t                beat_ctl;

  assign x_last = (BPS_W'(x_bit_q) + BPS_W'(1)) == nb_c;
  assign x_emit = x_v_q && beat_ready;
  assign x_take = !x_v_q || (x_emit && x_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_v_q   <= 1'b0;
      x_bit_q <= '0;
    end else if (x_take) begin
      x_v_q   <= s2_v_q;
      x_bit_q <= '0;
    end else if (x_emit) begin
      x_bit_q <= x_bit_q + BIT_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (x_take && s2_v_q) begin
      for (int k = 0; k < MAX_POINTS; k++) begin
        x_proj_q[k] <= PROJ_W'(s2_pre_q[k]) + PROJ_W'(s2_pim_q[k]);
      end
      x_zero_q <= zero_list_q;
      x_one_q  <= one_list_q;
    end
  end

  // Lane selection for the current bit. Lanes past the subset size repeat
  // the first entry, which leaves the maximum unchanged. A list entry that
  // names a point beyond the table selects a projection of zero.
  logic [POINT_REF_W-1:0]   zidx [TREE_LANES];
  logic [POINT_REF_W-1:0]   oidx [TREE_LANES];
  logic signed [PROJ_W-1:0] zval [TREE_LANES];
  logic signed [PROJ_W-1:0] oval [TREE_LANES];

  for (genvar j = 0; j < TREE_LANES; j++) begin : g_lane
    if (j < MAX_SUBSET) begin : g_used
      assign zidx[j] = (SUBSET_W'(j) < ns_c) ? x_zero_q[x_bit_q][j] : x_zero_q[x_bit_q][0];
      assign oidx[j] = (SUBSET_W'(j) < ns_c) ? x_one_q[x_bit_q][j] : x_one_q[x_bit_q][0];
    end else begin : g_pad
      assign zidx[j] = x_zero_q[x_bit_q][0];
      assign oidx[j] = x_one_q[x_bit_q][0];
    end
    assign zval[j] = ((POINT_REF_W+1)'(zidx[j]) < (POINT_REF_W+1)'(MAX_POINTS)) ?
                     x_proj_q[zidx[j][PT_IDX_W-1:0]] : '0;
    assign oval[j] = ((POINT_REF_W+1)'(oidx[j]) < (POINT_REF_W+1)'(MAX_POINTS)) ?
                     x_proj_q[oidx[j][PT_IDX_W-1:0]] : '0;
  end

  assign beat_ctl.bit_number = BIT_NUM_W'(x_bit_q);
  assign beat_ctl.last_bit   = x_last;

  // ---------------------------------------------------------------------------
  // Max tree and output register.
  // ---------------------------------------------------------------------------
  pmld_llr_pipe #(
    .PROJ_W (PROJ_W),
    .LLR_W  (LLR_W)
  ) u_llr_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (x_v_q),
    .beat_ready_o (beat_ready),
    .beat_ctl_i   (beat_ctl),
    .zero_val_i   (zval),
    .one_val_i    (oval),
    .llr_out      (llr_out)
  );

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // The serializer never runs past the configured bit count.
  a_x_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_v_q |-> (BPS_W'(x_bit_q) < nb_c))
    else $error("serializer bit index beyond bits per symbol");

  // A load item that leaves S1 never occupies the product stage.
  a_load_no_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && (s1_op_q != OP_DEMAP) && s2_rdy) |=> !s2_v_q)
    else $error("load item entered the product stage");

  // After the last beat leaves with nothing waiting in S2 the serializer is empty.
  a_x_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_emit && x_last && !s2_v_q) |=> !x_v_q)
    else $error("serializer still busy after its last beat");

endmodule

// ----- rtl/pmld_llr_pipe.sv -----
// -----------------------------------------------------------------------------
// pmld_llr_pipe: max reduction and LLR output stages
// Takes one bit's worth of selected projections per beat, reduces each set
// to its maximum over two registered levels and forms 2*(max0 - max1).
// -----------------------------------------------------------------------------
module pmld_llr_pipe #(
  parameter int unsigned PROJ_W = 2 * pmld_pkg::DEF_SAMPLE_WIDTH + 1,
  parameter int unsigned LLR_W  = 2 * pmld_pkg::DEF_SAMPLE_WIDTH + 3
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     beat_valid_i,
  output logic                     beat_ready_o,
  input  pmld_pkg::beat_ctl_t      beat_ctl_i,
  input  logic signed [PROJ_W-1:0] zero_val_i [pmld_pkg::TREE_LANES],
  input  logic signed [PROJ_W-1:0] one_val_i  [pmld_pkg::TREE_LANES],
  pmld_out_if.source               llr_out
);
  import pmld_pkg::*;

  function automatic logic signed [PROJ_W-1:0] smax(input logic signed [PROJ_W-1:0] a,
                                                    input logic signed [PROJ_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic                     r1_v_q, r2_v_q, r3_v_q, o_v_q;
  logic                     r1_rdy, r2_rdy, r3_rdy, o_rdy;
  beat_ctl_t                r1_ctl_q, r2_ctl_q, r3_ctl_q, o_ctl_q;
  logic signed [PROJ_W-1:0] r1_zero_q [TREE_LANES];
  logic signed [PROJ_W-1:0] r1_one_q  [TREE_LANES];
  logic signed [PROJ_W-1:0] r2_zero_q [TREE_HALF];
  logic signed [PROJ_W-1:0] r2_one_q  [TREE_HALF];
  logic signed [PROJ_W-1:0] r3_m0_q, r3_m1_q;
  logic signed [PROJ_W-1:0] m0_d, m1_d;
  logic signed [LLR_W-1:0]  diff;
  logic signed [LLR_W-1:0]  o_llr_d, o_llr_q;

  // Each stage moves on when it is empty or its successor moves on.
  assign o_rdy        = !o_v_q || llr_out.ready;
  assign r3_rdy       = !r3_v_q || o_rdy;
  assign r2_rdy       = !r2_v_q || r3_rdy;
  assign r1_rdy       = !r1_v_q || r2_rdy;
  assign beat_ready_o = r1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_v_q <= 1'b0;
      r2_v_q <= 1'b0;
      r3_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (r1_rdy) r1_v_q <= beat_valid_i;
      if (r2_rdy) r2_v_q <= r1_v_q;
      if (r3_rdy) r3_v_q <= r2_v_q;
      if (o_rdy)  o_v_q  <= r3_v_q;
    end
  end

  // Last two tree levels share one stage.
  assign m0_d = smax(smax(r2_zero_q[0], r2_zero_q[1]), smax(r2_zero_q[2], r2_zero_q[3]));
  assign m1_d = smax(smax(r2_one_q[0], r2_one_q[1]), smax(r2_one_q[2], r2_one_q[3]));

  assign diff    = LLR_W'(r3_m0_q) - LLR_W'(r3_m1_q);
  assign o_llr_d = diff <<< 1;

  always_ff @(posedge clk_i) begin
    if (r1_rdy && beat_valid_i) begin
      r1_zero_q <= zero_val_i;
      r1_one_q  <= one_val_i;
      r1_ctl_q  <= beat_ctl_i;
    end
    if (r2_rdy && r1_v_q) begin
      for (int i = 0; i < TREE_HALF; i++) begin
        r2_zero_q[i] <= smax(r1_zero_q[2*i], r1_zero_q[2*i+1]);
        r2_one_q[i]  <= smax(r1_one_q[2*i], r1_one_q[2*i+1]);
      end
      r2_ctl_q <= r1_ctl_q;
    end
    if (r3_rdy && r2_v_q) begin
      r3_m0_q  <= m0_d;
      r3_m1_q  <= m1_d;
      r3_ctl_q <= r2_ctl_q;
    end
    if (o_rdy && r3_v_q) begin
      o_llr_q <= o_llr_d;
      o_ctl_q <= r3_ctl_q;
    end
  end

  assign llr_out.valid      = o_v_q;
  assign llr_out.llr        = o_llr_q;
  assign llr_out.bit_number = o_ctl_q.bit_number;
  assign llr_out.last_bit   = o_ctl_q.last_bit;

endmodule

// ----- tb/sv/pmld_llr_check.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// pmld_llr_check: LLR predictor and comparator for the PSK demapper
// Watches the configuration port and both channels, keeps its own copy of the
// point table, the set lists and the registers, and compares every LLR
// transfer against the oldest predicted beat.
// -----------------------------------------------------------------------------
module pmld_llr_check (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pmld_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [pmld_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  pmld_in_if                               sample_ch,
  pmld_out_if                              llr_ch,
  output int unsigned                      fail_count,
  output int unsigned                      waiting_count
);
  import pmld_pkg::*;

  localparam int unsigned SW      = DEF_SAMPLE_WIDTH;
  localparam int unsigned LLR_W   = 2 * SW + 3;
  localparam int unsigned N_LISTS = DEF_MAX_BITS * DEF_MAX_SUBSET;

  typedef logic signed [SW-1:0] q214_t;
  typedef logic signed [2*SW:0] proj_t;

  typedef struct packed {
    logic signed [LLR_W-1:0] llr;
    logic [BIT_NUM_W-1:0]    bit_number;
    logic                    last_bit;
  } llr_beat_t;

  q214_t                  pt_re     [DEF_MAX_POINTS];
  q214_t                  pt_im     [DEF_MAX_POINTS];
  logic [POINT_REF_W-1:0] zero_refs [N_LISTS];
  logic [POINT_REF_W-1:0] one_refs  [N_LISTS];
  logic [BPS_W-1:0]       bps_reg;
  logic [SUBSET_W-1:0]    subset_reg;
  llr_beat_t              expected_llrs [$];
  int unsigned            mismatches;

  function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Projection of the sample onto every point, then a max over each set list.
  task automatic queue_llrs(input q214_t re, input q214_t im);
    proj_t       proj [DEF_MAX_POINTS];
    proj_t       best0;
    proj_t       best1;
    int unsigned nbits;
    int unsigned nsub;
    int unsigned k;
    int unsigned b;
    int unsigned j;
    int unsigned a;
    llr_beat_t   beat;
    nbits = clamp_cfg(bps_reg, DEF_MAX_BITS);
    nsub  = clamp_cfg(subset_reg, DEF_MAX_SUBSET);
    for (k = 0; k < DEF_MAX_POINTS; k++) begin
      proj[k] = re * pt_re[k] + im * pt_im[k];
    end
    for (b = 0; b < nbits; b++) begin
      best0 = '0;
      best1 = '0;
      for (j = 0; j < nsub; j++) begin
        a = b * DEF_MAX_SUBSET + j;
        if (j == 0 || proj[zero_refs[a]] > best0) best0 = proj[zero_refs[a]];
        if (j == 0 || proj[one_refs[a]] > best1) best1 = proj[one_refs[a]];
      end
      beat.llr        = 2 * (best0 - best1);
      beat.bit_number = BIT_NUM_W'(b);
      beat.last_bit   = (b + 1 == nbits);
      expected_llrs.push_back(beat);
    end
  endtask

  // Slot and reference fields cannot address outside the tables at these sizes,
  // so every load lands.
  task automatic take_item();
    case (opcode_e'(sample_ch.opcode))
      OP_LOAD_POINT: begin
        pt_re[sample_ch.point_slot] = sample_ch.sample_re;
        pt_im[sample_ch.point_slot] = sample_ch.sample_im;
      end
      OP_LOAD_ZERO: begin
        zero_refs[{sample_ch.bit_select, sample_ch.list_slot}] = sample_ch.point_ref;
      end
      OP_LOAD_ONE: begin
        one_refs[{sample_ch.bit_select, sample_ch.list_slot}] = sample_ch.point_ref;
      end
      default: begin
        queue_llrs(sample_ch.sample_re, sample_ch.sample_im);
      end
    endcase
  endtask

  task automatic check_llr();
    llr_beat_t got;
    llr_beat_t want;
    got.llr        = llr_ch.llr;
    got.bit_number = llr_ch.bit_number;
    got.last_bit   = llr_ch.last_bit;
    if (expected_llrs.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("pmld_llr_check: unexpected LLR %0d bit %0d last %0d at %0t",
                 got.llr, got.bit_number, got.last_bit, $realtime);
      end
    end else begin
      want = expected_llrs.pop_front();
      if (got.llr !== want.llr || got.bit_number !== want.bit_number ||
          got.last_bit !== want.last_bit) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("pmld_llr_check: expected llr %0d bit %0d last %0d, got llr %0d bit %0d last %0d",
                   want.llr, want.bit_number, want.last_bit,
                   got.llr, got.bit_number, got.last_bit);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bps_reg    = BPS_RESET;
      subset_reg = SUBSET_RESET;
      mismatches = 0;
      expected_llrs.delete();
      fail_count    <= 0;
      waiting_count <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_BITS_PER_SYMBOL: bps_reg = cfg_wdata_i[BPS_W-1:0];
          default:             subset_reg = cfg_wdata_i[SUBSET_W-1:0];
        endcase
      end
      if (sample_ch.valid && sample_ch.ready) take_item();
      if (llr_ch.valid && llr_ch.ready) check_llr();
      fail_count    <= mismatches;
      waiting_count <= expected_llrs.size();
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the PSK max-log LLR demapper
// Loads a 16-PSK table with one zero-set and one-set list per bit, sends
// corner samples under several register settings, then runs random phases of
// demap items and table reloads with random idling on both channels. The
// checker beside the block predicts and compares every LLR transfer.
// -----------------------------------------------------------------------------
module tb_top;
  import pmld_pkg::*;

  // The slowest correct run is far below this: roughly 200 items, four LLRs
  // each, every LLR waiting out the longest random receiver stall, plus sender
  // gaps and the long receiver hold.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Receiver hold during the back-pressure phase, long enough to fill the
  // block and stall its input several times over.
  localparam int unsigned LONG_HOLD   = 120;
  // Extra idle time at the end of each drain, as margin.
  localparam int unsigned DRAIN_WAIT  = 12;

  typedef logic signed [DEF_SAMPLE_WIDTH-1:0] q214_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;

  int unsigned fail_count;
  int unsigned waiting_count;
  int unsigned cycle_count = 0;

  // Idling controls. tx_gaps belongs to the stimulus process alone; the
  // receiver controls are written with nonblocking assignments because the
  // ready process reads them at the same clock edge.
  bit          tx_gaps;
  bit          rx_stalls;
  int unsigned hold_seq  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // Corner samples: zero, both full-scale diagonals, the two mixed corners
  // and one unit-amplitude sample on the real axis.
  q214_t corner_re [6] = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh4000};
  q214_t corner_im [6] = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh0000};

  pmld_in_if  sample_in ();
  pmld_out_if llr_out ();

  psk_maxlog_llr_demapper uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_in   (sample_in),
    .llr_out     (llr_out)
  );

  pmld_llr_check demap_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .sample_ch     (sample_in),
    .llr_ch        (llr_out),
    .fail_count    (fail_count),
    .waiting_count (waiting_count)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // Random Q2.14 value with the extremes and zero drawn often.
  function automatic q214_t rand_q214();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      default: return q214_t'($urandom);
    endcase
  endfunction

  // Receiver side. A change of hold_seq starts the long hold; otherwise ready
  // drops for random stretches while rx_stalls is set.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      llr_out.ready <= 1'b0;
      hold_left     <= 0;
    end else if (hold_seq != hold_seen) begin
      hold_seen     <= hold_seq;
      hold_left     <= LONG_HOLD;
      llr_out.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      llr_out.ready <= 1'b0;
    end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
      hold_left     <= pick_gap() - 1;
      llr_out.ready <= 1'b0;
    end else begin
      llr_out.ready <= 1'b1;
    end
  end

  // Watchdog: a hung block or a lost LLR ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Offers one item and returns at the edge where it is transferred, or at the end
  // of a random gap after it. Valid is left high unless a gap follows, so
  // back-to-back items never see valid lowered and raised within one time step.
  // The caller either sends the next item or calls drain in that same step.
  task automatic push_item(input opcode_e op, input logic [POINT_SLOT_W-1:0] pslot,
                           input logic [BIT_SEL_W-1:0] bsel,
                           input logic [LIST_SLOT_W-1:0] lslot,
                           input logic [POINT_REF_W-1:0] pref, input q214_t re,
                           input q214_t im);
    sample_in.valid      <= 1'b1;
    sample_in.opcode     <= op;
    sample_in.point_slot <= pslot;
    sample_in.bit_select <= bsel;
    sample_in.list_slot  <= lslot;
    sample_in.point_ref  <= pref;
    sample_in.sample_re  <= re;
    sample_in.sample_im  <= im;
    @(posedge clk_i);
    while (!sample_in.ready) @(posedge clk_i);
    if (tx_gaps && $urandom_range(0, 2) == 0) begin
      sample_in.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
  endtask

  // Demap item; the fields that a demap ignores still carry random bits.
  task automatic push_sample(input q214_t re, input q214_t im);
    push_item(OP_DEMAP, POINT_SLOT_W'($urandom), BIT_SEL_W'($urandom),
              LIST_SLOT_W'($urandom), POINT_REF_W'($urandom), re, im);
  endtask

  task automatic push_corners();
    int k;
    for (k = 0; k < 6; k++) push_sample(corner_re[k], corner_im[k]);
  endtask

  // Stops offering and waits until every predicted LLR has been transferred.
  // The first edge lets the checker count the item transferred in this step.
  // Loads produce nothing, so the extra wait lets them clear before the next step.
  task automatic drain(input int unsigned extra);
    sample_in.valid <= 1'b0;
    @(posedge clk_i);
    while (waiting_count != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Writes both registers on consecutive edges, keeping the write enable high
  // across them.
  task automatic set_config(input logic [CFG_DATA_W-1:0] bps,
                            input logic [CFG_DATA_W-1:0] subset);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_BITS_PER_SYMBOL;
    cfg_wdata_i <= bps;
    @(posedge clk_i);
    cfg_index_i <= CFG_SUBSET_SIZE;
    cfg_wdata_i <= subset;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random traffic: mostly samples, with point reloads and set-list rewrites
  // mixed in. Every table entry holds a defined value by now, so any rewrite
  // keeps the tables fully written.
  task automatic run_phase(input int unsigned n_items);
    int unsigned i;
    int unsigned pick;
    for (i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        push_sample(rand_q214(), rand_q214());
      end else if (pick < 9) begin
        push_item(OP_LOAD_POINT, POINT_SLOT_W'($urandom), BIT_SEL_W'($urandom),
                  LIST_SLOT_W'($urandom), POINT_REF_W'($urandom), rand_q214(),
                  rand_q214());
      end else begin
        push_item($urandom_range(0, 1) ? OP_LOAD_ZERO : OP_LOAD_ONE,
                  POINT_SLOT_W'($urandom), BIT_SEL_W'($urandom),
                  LIST_SLOT_W'($urandom), POINT_REF_W'($urandom), q214_t'($urandom),
                  q214_t'($urandom));
      end
    end
  endtask

  initial begin
    int     k;
    int     b;
    int     j;
    int     ph;
    int     zero_pt;
    real    ang;
    sample_in.valid      = 1'b0;
    sample_in.opcode     = OP_LOAD_POINT;
    sample_in.point_slot = '0;
    sample_in.bit_select = '0;
    sample_in.list_slot  = '0;
    sample_in.point_ref  = '0;
    sample_in.sample_re  = '0;
    sample_in.sample_im  = '0;
    cfg_we_i             = 1'b0;
    cfg_index_i          = CFG_BITS_PER_SYMBOL;
    cfg_wdata_i          = '0;
    rst_ni               = 1'b0;
    tx_gaps              = 1'b0;
    rx_stalls            = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Table setup with idling on both sides: sixteen unit-circle points, then
    // for each bit the eight points with that bit clear (zero-set) and set
    // (one-set). Nothing is demapped before every entry has been written.
    tx_gaps = 1'b1;
    rx_stalls <= 1'b1;
    for (k = 0; k < DEF_MAX_POINTS; k++) begin
      ang = 6.283185307179586 * k / DEF_MAX_POINTS;
      push_item(OP_LOAD_POINT, POINT_SLOT_W'(k), BIT_SEL_W'($urandom),
                LIST_SLOT_W'($urandom), POINT_REF_W'($urandom),
                q214_t'(int'($cos(ang) * 16384.0)), q214_t'(int'($sin(ang) * 16384.0)));
    end
    for (b = 0; b < DEF_MAX_BITS; b++) begin
      for (j = 0; j < DEF_MAX_SUBSET; j++) begin
        zero_pt = ((j >> b) << (b + 1)) | (j & ((1 << b) - 1));
        push_item(OP_LOAD_ZERO, POINT_SLOT_W'($urandom), BIT_SEL_W'(b), LIST_SLOT_W'(j),
                  POINT_REF_W'(zero_pt), q214_t'($urandom), q214_t'($urandom));
        push_item(OP_LOAD_ONE, POINT_SLOT_W'($urandom), BIT_SEL_W'(b), LIST_SLOT_W'(j),
                  POINT_REF_W'(zero_pt | (1 << b)), q214_t'($urandom), q214_t'($urandom));
      end
    end

    // Corner samples under the reset setting of two bits and two-entry lists.
    push_corners();

    // Full-scale points at the head of bit 0's lists: the largest positive
    // projection against the most negative one gives the widest LLR.
    push_item(OP_LOAD_POINT, 4'd0, BIT_SEL_W'($urandom), LIST_SLOT_W'($urandom),
              POINT_REF_W'($urandom), 16'sh8000, 16'sh8000);
    push_item(OP_LOAD_POINT, 4'd1, BIT_SEL_W'($urandom), LIST_SLOT_W'($urandom),
              POINT_REF_W'($urandom), 16'sh7fff, 16'sh7fff);
    drain(DRAIN_WAIT);

    // Both registers written as zero: one bit per symbol, one-entry lists.
    set_config('0, '0);
    push_sample(16'sh8000, 16'sh8000);
    push_sample(16'sh7fff, 16'sh7fff);
    push_sample(16'sh0000, 16'sh0000);
    drain(DRAIN_WAIT);

    // All ones: both registers beyond their maximum, so four bits and
    // eight-entry lists.
    set_config('1, '1);
    push_corners();
    drain(DRAIN_WAIT);

    // Random phases. The second one applies back-pressure: the receiver holds
    // off for a long stretch while the sender offers items without gaps, so
    // the block fills up and stalls its input. Every phase ends with the
    // sender paused until the last LLR has been transferred.
    for (ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        set_config(4'd1, 4'd1);
      end else if (ph == 1) begin
        set_config(4'd4, 4'd8);
      end else begin
        set_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
      end
      if (ph == 1) begin
        tx_gaps = 1'b0;
        rx_stalls <= 1'b0;
        hold_seq  <= hold_seq + 1;
        run_phase(30);
      end else begin
        tx_gaps = $urandom_range(0, 2) != 0;
        rx_stalls <= $urandom_range(0, 2) != 0;
        run_phase(12);
      end
      drain(DRAIN_WAIT);
    end

    drain(2 * DRAIN_WAIT);
    if (fail_count == 0 && waiting_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
